/* hw/rtl/hsw_pkg.sv */
// Shared types, constants and arithmetic helpers for the Haas stereo widener.
package hsw_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FRAME_W  = 2 * SAMPLE_W;
   localparam int SIDE_W   = 16;
   localparam int DELAY_W  = 12;
   localparam int GAIN_W   = 18;
   localparam int PROD_W   = SAMPLE_W + GAIN_W;
   localparam int RND_W    = PROD_W + 1 - 15;
   localparam int CSR_W    = 16;

   localparam logic [SIDE_W-1:0]  SIDE_GAIN_RESET = 16'd8192;
   localparam logic [DELAY_W-1:0] DELAY_RESET     = 12'd960;

   typedef enum logic [1:0] {
      CSR_SIDE_GAIN    = 2'd0,
      CSR_DELAY_FRAMES = 2'd1
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   // Q.15 product to integer, round half to even.
   function automatic logic signed [RND_W-1:0] round_q15(input prod_type p);
      logic signed [PROD_W:0] t;
      t = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(16'h3FFF))
          + $signed((PROD_W+1)'(p[15]));
      return RND_W'(t >>> 15);
   endfunction

   function automatic sample_type sat16(input logic signed [RND_W:0] v);
      sample_type r;
      if (v > 32767) begin
         r = 16'sh7FFF;
      end else if (v < -32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/hsw_history_ram.sv */
// Frame history memory: one write port, two registered read ports.
module hsw_history_ram #(
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [hsw_pkg::FRAME_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr_a,
   input  logic [AW-1:0]               rd_addr_b,
   output logic [hsw_pkg::FRAME_W-1:0] rd_data_a,
   output logic [hsw_pkg::FRAME_W-1:0] rd_data_b
);
   import hsw_pkg::*;

   logic [FRAME_W-1:0] mem [DEPTH];

   // Read returns the old entry when the same address is written in this cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

/* hw/rtl/haas_stereo_widener.sv */
// Haas-effect stereo widener: top level with history memory and mix pipeline.
//
// One stereo frame per clock unless stalled, via the stage 1, stage 2 and output
// registers. left_out = side*L[n] + center*L[n-D], right_out = center*R[n-D] +
// side*R[n-2D], center = 1.0 - 2*side, Q1.15 gains, products rounded half to
// even, sums saturated to 16 bits. Each frame is written to a history memory of
// TAP_MULTIPLE*MAX_DELAY frames in the cycle it is accepted, and both delayed
// taps are read from the memory's two read ports in that same cycle, so the
// rate is set by that single memory access per frame. The delayed taps are
// muted until D (resp. 2D) frames have been seen since reset or the last delay
// write, so the memory needs no clearing pass. Write configuration only while
// the block is idle; a delay write restarts warm-up, a side gain write does not.
module haas_stereo_widener #(
   parameter int MAX_DELAY    = 2048,
   parameter int TAP_MULTIPLE = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [15:0]            req_left_in,
   input  logic signed [15:0]            req_right_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [15:0]            rsp_left_out,
   output logic signed [15:0]            rsp_right_out,
   input  logic                          csr_write,
   input  hsw_pkg::csr_index_type        csr_index,
   input  logic [hsw_pkg::CSR_W-1:0]     csr_wdata
);
   import hsw_pkg::*;

   localparam int DEPTH = TAP_MULTIPLE * MAX_DELAY;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = $clog2(MAX_DELAY + 1);
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int CW    = DW + DELAY_W;

   // Configuration
   logic [SIDE_W-1:0]  side_gain_ff;
   logic [DELAY_W-1:0] delay_ff;

   // Pointer and warm-up count
   logic [AW-1:0] wp_ff, wp_in;
   logic [FW-1:0] frames_ff, frames_in;

   // Pipeline
   logic                s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   sample_type          s1_left_ff, s1_right_ff;
   logic                s1_gate1_ff, s1_gate2_ff;
   prod_type            s2_lcur_ff, s2_ldel_ff, s2_rdel_ff, s2_rdel2_ff;
   sample_type          out_left_ff, out_right_ff;

   logic                s1_ready, s2_ready, s3_ready, req_accept;
   logic [DW-1:0]       dist1;
   logic [FW-1:0]       dist2;
   logic [CW-1:0]       delay_ext;
   logic [AW:0]         diff1, diff2;
   logic [AW-1:0]       addr1, addr2;
   logic [FRAME_W-1:0]  rd_tap1, rd_tap2;
   logic                gate1, gate2;
   logic signed [GAIN_W-1:0] side_s, center_s;
   sample_type          ldel, rdel, rdel2;
   logic signed [RND_W:0] lsum, rsum;

   // Flow control: each stage moves when the next one is empty or moving.
   assign s3_ready   = !rsp_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;

   // Effective delay: clamp to 1..MAX_DELAY.
   always_comb begin
      delay_ext = CW'(delay_ff);
      if (delay_ff == '0) begin
         dist1 = DW'(1);
      end else if (delay_ext > CW'(MAX_DELAY)) begin
         dist1 = DW'(MAX_DELAY);
      end else begin
         dist1 = delay_ext[DW-1:0];
      end
      dist2 = FW'(FW'(dist1) * FW'(TAP_MULTIPLE));
   end

   // Tap addresses, wrapped at the memory depth.
   always_comb begin
      diff1 = {1'b0, wp_ff} - (AW+1)'(dist1);
      diff2 = {1'b0, wp_ff} - (AW+1)'(dist2);
      addr1 = diff1[AW] ? AW'(diff1 + (AW+1)'(DEPTH)) : diff1[AW-1:0];
      addr2 = diff2[AW] ? AW'(diff2 + (AW+1)'(DEPTH)) : diff2[AW-1:0];
      gate1 = frames_ff >= FW'(dist1);
      gate2 = frames_ff >= dist2;
   end

   always_comb begin
      wp_in     = wp_ff;
      frames_in = frames_ff;
      if (req_accept) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         if (frames_ff < dist2) begin
            frames_in = frames_ff + FW'(1);
         end
      end
      if (csr_write && csr_index == CSR_DELAY_FRAMES) begin
         frames_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_gain_ff <= SIDE_GAIN_RESET;
         delay_ff     <= DELAY_RESET;
         wp_ff        <= '0;
         frames_ff    <= '0;
      end else begin
         wp_ff     <= wp_in;
         frames_ff <= frames_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SIDE_GAIN:    side_gain_ff <= csr_wdata[SIDE_W-1:0];
               CSR_DELAY_FRAMES: delay_ff     <= csr_wdata[DELAY_W-1:0];
               default: ;
            endcase
         end
      end
   end

   hsw_history_ram #(
      .DEPTH(DEPTH)
   ) u_history (
      .clock     (clock),
      .wr_en     (req_accept),
      .wr_addr   (wp_ff),
      .wr_data   ({req_right_in, req_left_in}),
      .rd_en     (req_accept),
      .rd_addr_a (addr1),
      .rd_addr_b (addr2),
      .rd_data_a (rd_tap1),
      .rd_data_b (rd_tap2)
   );

   // Stage 1: memory read in flight, hold the current frame and tap gates.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_left_ff  <= req_left_in;
         s1_right_ff <= req_right_in;
         s1_gate1_ff <= gate1;
         s1_gate2_ff <= gate2;
      end
   end

   // Stage 2: four products. Muted taps multiply a zero sample.
   always_comb begin
      side_s   = $signed({2'b00, side_gain_ff});
      center_s = 18'sd32768 - $signed({1'b0, side_gain_ff, 1'b0});
      ldel     = s1_gate1_ff ? $signed(rd_tap1[SAMPLE_W-1:0]) : '0;
      rdel     = s1_gate1_ff ? $signed(rd_tap1[FRAME_W-1:SAMPLE_W]) : '0;
      rdel2    = s1_gate2_ff ? $signed(rd_tap2[FRAME_W-1:SAMPLE_W]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_lcur_ff  <= s1_left_ff * side_s;
         s2_ldel_ff  <= ldel * center_s;
         s2_rdel_ff  <= rdel * center_s;
         s2_rdel2_ff <= rdel2 * side_s;
      end
   end

   // Stage 3: round, add, saturate into the output register.
   always_comb begin
      lsum = (RND_W+1)'(round_q15(s2_lcur_ff)) + (RND_W+1)'(round_q15(s2_ldel_ff));
      rsum = (RND_W+1)'(round_q15(s2_rdel_ff)) + (RND_W+1)'(round_q15(s2_rdel2_ff));
      lsum = $signed({lsum[RND_W-1], lsum[RND_W-1:0]})
             + $signed({{1{1'b0}}, {RND_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         out_left_ff  <= sat16(lsum);
         out_right_ff <= sat16(rsum);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = out_left_ff;
   assign rsp_right_out = out_right_ff;

   // Warm-up count never passes the far tap distance.
   a_frames_bounded: assert property (@(posedge clock) disable iff (reset)
      frames_ff <= dist2)
      else $error("warm-up count above far tap distance");

   // The far tap is never live while the near tap is muted.
   a_gate_order: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_gate2_ff |-> s1_gate1_ff)
      else $error("far tap enabled before near tap");

   // The write pointer moves only on an accepted frame.
   a_wp_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(wp_ff))
      else $error("write pointer moved without a frame");

   // An accepted frame always lands in stage 1.
   a_accept_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted frame lost before stage 1");

   // A held output beat keeps the stages behind it from overrunning it.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && s2_valid_ff |-> !s2_ready)
      else $error("stage 2 advanced into a held output");

endmodule

/* test/hsw_mix_checker.sv */
`timescale 1ns / 1ps
// Beat monitor and frame predictor for the Haas stereo widener, with result checking.
module hsw_mix_checker #(
   parameter int MAX_DELAY    = 2048,
   parameter int TAP_MULTIPLE = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [15:0]            req_left_in,
   input  logic signed [15:0]            req_right_in,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [15:0]            rsp_left_out,
   input  logic signed [15:0]            rsp_right_out,
   input  logic                          csr_write,
   input  hsw_pkg::csr_index_type        csr_index,
   input  logic [hsw_pkg::CSR_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            frames_pending
);
   import hsw_pkg::*;

   localparam int STORE_DEPTH = TAP_MULTIPLE * MAX_DELAY;

   typedef struct {
      sample_type left;
      sample_type right;
   } frame_type;

   logic [FRAME_W-1:0] history [STORE_DEPTH];
   int                 wr_ptr      = 0;
   int                 frames_seen = 0;
   int                 errors      = 0;
   logic [SIDE_W-1:0]  side_gain   = SIDE_GAIN_RESET;
   logic [DELAY_W-1:0] delay_cfg   = DELAY_RESET;
   frame_type          expected_frames [$];

   initial begin
      fail_count     = 0;
      frames_pending = 0;
   end

   // effective Haas offset: zero acts as one, large values clip to the store half
   function automatic int tap_distance();
      int d;
      d = delay_cfg;
      if (d < 1) d = 1;
      if (d > MAX_DELAY) d = MAX_DELAY;
      return d;
   endfunction

   function automatic longint scale_q15(input longint s, input longint g);
      longint p;
      longint a;
      longint q;
      longint r;
      p = s * g;
      a = (p < 0) ? -p : p;
      q = a >>> 15;
      r = a & 64'h7FFF;
      // round half to even on the magnitude
      if (r > 64'h4000 || (r == 64'h4000 && q[0])) q++;
      return (p < 0) ? -q : q;
   endfunction

   function automatic sample_type clamp16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return sample_type'(v);
   endfunction

   function automatic frame_type widen_frame(input sample_type l, input sample_type r);
      int                 d;
      longint             side;
      longint             center;
      longint             lo;
      longint             ro;
      logic [FRAME_W-1:0] e;
      frame_type          f;
      d      = tap_distance();
      side   = side_gain;
      center = 32768 - 2 * side;
      lo     = scale_q15(l, side);
      ro     = 0;
      if (frames_seen >= d) begin
         e  = history[(wr_ptr + STORE_DEPTH - d) % STORE_DEPTH];
         lo += scale_q15($signed(e[15:0]), center);
         ro += scale_q15($signed(e[31:16]), center);
      end
      if (frames_seen >= TAP_MULTIPLE * d) begin
         e  = history[(wr_ptr + STORE_DEPTH - TAP_MULTIPLE * d) % STORE_DEPTH];
         ro += scale_q15($signed(e[31:16]), side);
      end
      f.left  = clamp16(lo);
      f.right = clamp16(ro);
      return f;
   endfunction

   always @(posedge clock) begin : monitor
      frame_type want;
      if (reset) begin
         wr_ptr      = 0;
         frames_seen = 0;
         side_gain   = SIDE_GAIN_RESET;
         delay_cfg   = DELAY_RESET;
         expected_frames.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SIDE_GAIN: begin
                  side_gain = csr_wdata[SIDE_W-1:0];
               end
               CSR_DELAY_FRAMES: begin
                  delay_cfg   = csr_wdata[DELAY_W-1:0];
                  frames_seen = 0;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_frames.push_back(widen_frame(req_left_in, req_right_in));
            history[wr_ptr] = {req_right_in, req_left_in};
            wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
            if (frames_seen < TAP_MULTIPLE * tap_distance()) frames_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               errors++;
               $error("result beat with no frame outstanding: left_out %0d right_out %0d",
                      rsp_left_out, rsp_right_out);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_left_out !== want.left) begin
                  errors++;
                  $error("left_out: expected %0d, got %0d", want.left, rsp_left_out);
               end
               if (rsp_right_out !== want.right) begin
                  errors++;
                  $error("right_out: expected %0d, got %0d", want.right, rsp_right_out);
               end
            end
         end
      end
      fail_count     <= errors;
      frames_pending <= expected_frames.size();
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Top-level bench for the Haas stereo widener: clock, reset, stimulus and verdict.
module tb;
   import hsw_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DEEP_FRAMES    = 700;
   localparam int PHASE_FRAMES   = 100;

   logic          clock        = 1'b0;
   logic          reset        = 1'b1;
   logic          req_valid    = 1'b0;
   logic          req_stall;
   sample_type    req_left_in  = '0;
   sample_type    req_right_in = '0;
   logic          rsp_valid;
   logic          rsp_stall    = 1'b0;
   sample_type    rsp_left_out;
   sample_type    rsp_right_out;
   logic          csr_write    = 1'b0;
   csr_index_type csr_index    = CSR_SIDE_GAIN;
   logic [CSR_W-1:0] csr_wdata = '0;

   int fail_count;
   int frames_pending;
   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;

   always #6 clock = ~clock;

   haas_stereo_widener dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_left_in  (req_left_in),
      .req_right_in (req_right_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_left_out (rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   hsw_mix_checker mix_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .frames_pending(frames_pending)
   );

   task automatic send_frame(input int l, input int r);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= sample_type'(l);
      req_right_in <= sample_type'(r);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and wait until every frame sent has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_sample();
      case ($urandom_range(0, 9))
         0: return 32767;
         1: return -32768;
         2: return int'($urandom_range(0, 64)) - 32;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   function automatic int pick_delay();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return $urandom_range(2049, 4095);
         2: return $urandom_range(61, 2048);
         default: return $urandom_range(1, 60);
      endcase
   endfunction

   // receiver side: short random stalls, plus one long hold on request
   initial begin : receiver
      int n;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int side;
      int dly;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: long delay, only the direct side term is live
      send_frame(32767, -32768);
      send_frame(-32768, 32767);
      send_frame(0, 0);
      send_frame(-1, 1);
      send_frame(1, -1);
      drain();

      // half side gain, zero center, delay zero acts as one: rounding ties
      write_reg(CSR_SIDE_GAIN, 16384);
      write_reg(CSR_DELAY_FRAMES, 0);
      send_frame(1, -1);
      send_frame(3, -3);
      send_frame(-3, 3);
      send_frame(32767, -32768);
      send_frame(-32768, 32767);
      drain();

      // full side gain, center of minus one: saturate both ways
      write_reg(CSR_SIDE_GAIN, 32768);
      write_reg(CSR_DELAY_FRAMES, 1);
      send_frame(32767, 32767);
      send_frame(-32768, -32768);
      send_frame(32767, -32768);
      send_frame(5, -5);
      drain();

      // top of the gain field, delay beyond the store half
      write_reg(CSR_SIDE_GAIN, 65535);
      write_reg(CSR_DELAY_FRAMES, 4095);
      send_frame(32767, -32768);
      send_frame(-32768, 32767);
      send_frame(1000, -1000);
      drain();

      // center only: outputs are the delayed frames
      write_reg(CSR_SIDE_GAIN, 0);
      write_reg(CSR_DELAY_FRAMES, 2);
      for (int i = 0; i < 6; i++) send_frame(i * 1111 - 3000, 2500 - i * 977);
      drain();

      // moderate delay, long enough to warm both taps and run on with them live
      write_reg(CSR_SIDE_GAIN, $urandom_range(0, 32768));
      write_reg(CSR_DELAY_FRAMES, 300);
      for (int i = 0; i < DEEP_FRAMES; i++) begin
         if (i == 300) hold_request = 1'b1;
         send_frame(pick_sample(), pick_sample());
      end
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         idle_on = (ph % 3 != 2) && (ph != 7);
         case (ph)
            0: side = 0;
            1: side = 32768;
            2: side = 16384;
            3: side = 65535;
            4: side = $urandom & 16'hFFFF;
            default: side = $urandom_range(0, 32768);
         endcase
         write_reg(CSR_SIDE_GAIN, side);
         // a gain write alone keeps the warm taps
         if (ph < 2 || $urandom_range(0, 2) != 0) begin
            dly = (ph == 0) ? 1 : (ph == 1) ? 2 : pick_delay();
            write_reg(CSR_DELAY_FRAMES, dly);
         end
         repeat (PHASE_FRAMES) send_frame(pick_sample(), pick_sample());
         drain();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && frames_pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/hsw_pkg.sv
hw/rtl/hsw_history_ram.sv
hw/rtl/haas_stereo_widener.sv
test/hsw_mix_checker.sv
test/tb.sv
